>>> sv/tcc_pkg.sv
// Shared constants, codes and control types for the text console cursor and scroll engine.
package tcc_pkg;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;
    logic exec;
    logic scr_rd;
    logic scr_wr;
    logic clr_wr;
    logic load_out;
  } tcc_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic put_scroll;
    logic last_copy;
    logic last_cell;
    logic out_free;
  } tcc_sts_t;

endpackage

>>> sv/tcc_if.sv
// Valid/ready channel interfaces for console requests and results.
interface tcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcc_pkg::FUNC_W-1:0] func;
  logic [tcc_pkg::CHAR_W-1:0] char_code;
  logic [tcc_pkg::CHAR_W-1:0] attrib;
  logic [tcc_pkg::COL_W-1:0]  col;
  logic [tcc_pkg::ROW_W-1:0]  row;
  logic                       end_of_text;

  modport source (output valid, func, char_code, attrib, col, row, end_of_text, input ready);
  modport sink   (input valid, func, char_code, attrib, col, row, end_of_text, output ready);
endinterface

interface tcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcc_pkg::COL_W-1:0]  cursor_col;
  logic [tcc_pkg::ROW_W-1:0]  cursor_row;
  logic [tcc_pkg::CHAR_W-1:0] cell_char;
  logic [tcc_pkg::CHAR_W-1:0] cell_attr;
  logic                       scrolled;
  logic                       bad_position;
  logic                       text_done;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  bad_position, text_done, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  bad_position, text_done, output ready);
endinterface

>>> sv/tcc_ctrl.sv
// Controller state machine: clearing pass, request execution, scroll sweep and result hand-off.
module tcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcc_pkg::tcc_sts_t sts,
  output tcc_pkg::tcc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_CLR,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.last_cell) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.put_scroll ? ST_SCR_RD : ST_FINISH;
      end
      ST_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        state_nxt  = sts.last_copy ? ST_SCR_CLR : ST_SCR_RD;
      end
      ST_SCR_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.last_cell) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/tcc_dp.sv
// Datapath: request registers, cursor, screen memory, sweep pointer and result register.
module tcc_dp #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcc_pkg::tcc_cmd_t          cmd,
  output tcc_pkg::tcc_sts_t          sts,
  input  logic [tcc_pkg::FUNC_W-1:0] in_func,
  input  logic [tcc_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcc_pkg::CHAR_W-1:0] in_attrib,
  input  logic [tcc_pkg::COL_W-1:0]  in_col,
  input  logic [tcc_pkg::ROW_W-1:0]  in_row,
  input  logic                       in_end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcc_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tcc_pkg::CHAR_W-1:0] out_cell_char,
  output logic [tcc_pkg::CHAR_W-1:0] out_cell_attr,
  output logic                       out_scrolled,
  output logic                       out_bad_position,
  output logic                       out_text_done
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = 2 * tcc_pkg::CHAR_W;

  // Latched request.
  logic [tcc_pkg::FUNC_W-1:0] func_r;
  logic [tcc_pkg::CHAR_W-1:0] ch_r, at_r;
  logic [tcc_pkg::COL_W-1:0]  col_r;
  logic [tcc_pkg::ROW_W-1:0]  row_r;
  logic                       eot_r;
  logic                       scr_r, bad_r, rdv_r;

  logic [tcc_pkg::COL_W-1:0]  cur_x_r, cur_x_nxt;
  logic [tcc_pkg::ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [AW-1:0]              ptr_r;

  logic [CW-1:0] mem [CELLS];
  logic [CW-1:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra, pos_addr;
  logic [CW-1:0] mem_wd;

  logic out_valid_r;

  logic is_put, is_set, is_read, is_newline, in_range, at_last_col, at_last_row;
  logic [tcc_pkg::COL_W-1:0] sel_x;
  logic [tcc_pkg::ROW_W-1:0] sel_y;

  assign is_put      = (func_r == tcc_pkg::FUNC_PUT);
  assign is_set      = (func_r == tcc_pkg::FUNC_SET);
  assign is_read     = (func_r == tcc_pkg::FUNC_READ);
  assign is_newline  = (ch_r == tcc_pkg::NEWLINE_CODE);
  assign in_range    = ({1'b0, col_r} < (tcc_pkg::COL_W + 1)'(COLUMNS)) &&
                       ({1'b0, row_r} < (tcc_pkg::ROW_W + 1)'(ROWS));
  assign at_last_col = (cur_x_r == tcc_pkg::COL_W'(COLUMNS - 1));
  assign at_last_row = (cur_y_r == tcc_pkg::ROW_W'(ROWS - 1));

  // One row-major address computation, shared by the cursor write and the cell read.
  assign sel_x    = is_read ? col_r : cur_x_r;
  assign sel_y    = is_read ? row_r : cur_y_r;
  assign pos_addr = AW'(AW'(sel_y) * AW'(COLUMNS)) + AW'(sel_x);

  assign sts.put_scroll = is_put && at_last_row && (is_newline || at_last_col);
  assign sts.last_copy  = (ptr_r == AW'(COPY_N - 1));
  assign sts.last_cell  = (ptr_r == AW'(CELLS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    mem_we = (cmd.exec && is_put && !is_newline) || cmd.scr_wr || cmd.clr_wr;
    mem_wa = (cmd.scr_wr || cmd.clr_wr) ? ptr_r : pos_addr;
    if (cmd.clr_wr) begin
      mem_wd = '0;
    end else if (cmd.scr_wr) begin
      mem_wd = rd_data_r;
    end else begin
      mem_wd = {at_r, ch_r};
    end
    mem_re = (cmd.exec && is_read && in_range) || cmd.scr_rd;
    mem_ra = cmd.scr_rd ? (ptr_r + AW'(COLUMNS)) : pos_addr;
  end

  // Cursor: put steps right, wraps at row end, pins to last row on scroll; set moves it.
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (cmd.exec) begin
      if (is_put) begin
        if (sts.put_scroll) begin
          cur_x_nxt = '0;
          cur_y_nxt = tcc_pkg::ROW_W'(ROWS - 1);
        end else if (is_newline || at_last_col) begin
          cur_x_nxt = '0;
          cur_y_nxt = cur_y_r + tcc_pkg::ROW_W'(1);
        end else begin
          cur_x_nxt = cur_x_r + tcc_pkg::COL_W'(1);
        end
      end else if (is_set && in_range) begin
        cur_x_nxt = col_r;
        cur_y_nxt = row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      func_r <= in_func;
      ch_r   <= in_char_code;
      at_r   <= in_attrib;
      col_r  <= in_col;
      row_r  <= in_row;
      eot_r  <= in_end_of_text;
      scr_r  <= 1'b0;
      bad_r  <= 1'b0;
      rdv_r  <= 1'b0;
    end else if (cmd.exec) begin
      scr_r <= sts.put_scroll;
      bad_r <= (is_set || is_read) && !in_range;
      rdv_r <= is_read && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      if (cmd.scr_wr || cmd.clr_wr) begin
        ptr_r <= sts.last_cell ? '0 : ptr_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cursor_col   <= cur_x_r;
      out_cursor_row   <= cur_y_r;
      out_cell_char    <= rdv_r ? rd_data_r[tcc_pkg::CHAR_W-1:0] : '0;
      out_cell_attr    <= rdv_r ? rd_data_r[CW-1:tcc_pkg::CHAR_W] : '0;
      out_scrolled     <= scr_r;
      out_bad_position <= bad_r;
      out_text_done    <= eot_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/text_console_cursor_scroll.sv
// Top level of the text console engine: controller and datapath on two valid/ready channels.
//
// Requests arrive on in_chan: func 0 prints one character at the cursor (code 10 is a newline),
// func 1 moves the cursor, func 2 reads back one cell. Out-of-range positions for func 1 and 2
// are reported in bad_position and change nothing; func 3 only reports the cursor. Every
// request gives exactly one result transaction on out_chan with the cursor after the request.
//
// A request is taken in the idle state, executed in the exec state, and its result is loaded
// into the output register in the finish state once that register is free. A print that runs
// off the bottom row scrolls the screen: between execution and the finish state a sweep through
// the screen memory reads each of the (ROWS-1)*COLUMNS moved cells one row down and writes it
// one row up, then clears the bottom row of COLUMNS cells.
//
// After reset the cursor is at the top left and a clearing pass writes zero to all
// ROWS*COLUMNS cells, one per cycle; in_chan.ready stays low until it finishes. The result
// sits in an output register, so the next request is taken while a result waits; if the
// receiver stalls, that request completes its work and then holds until the output register
// frees up.
module text_console_cursor_scroll #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input logic clk,
  input logic rst_n,
  tcc_in_if.sink    in_chan,
  tcc_out_if.source out_chan
);

  tcc_pkg::tcc_cmd_t cmd;
  tcc_pkg::tcc_sts_t sts;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the screen memory and the cursor; the controller only sequences it.
  tcc_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_chan.func),
    .in_char_code     (in_chan.char_code),
    .in_attrib        (in_chan.attrib),
    .in_col           (in_chan.col),
    .in_row           (in_chan.row),
    .in_end_of_text   (in_chan.end_of_text),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_cursor_col   (out_chan.cursor_col),
    .out_cursor_row   (out_chan.cursor_row),
    .out_cell_char    (out_chan.cell_char),
    .out_cell_attr    (out_chan.cell_attr),
    .out_scrolled     (out_chan.scrolled),
    .out_bad_position (out_chan.bad_position),
    .out_text_done    (out_chan.text_done)
  );

endmodule
